/* hw/rtl/midi_controller_value_mapper_defines.svh */
// assertion macros for the midi controller value mapper
`ifndef MIDI_CONTROLLER_VALUE_MAPPER_DEFINES_SVH
`define MIDI_CONTROLLER_VALUE_MAPPER_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define MCVM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define MCVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mcvm_pkg.sv */
// shared types, codes and the mode table of the midi controller value mapper
`timescale 1ns / 1ps
`default_nettype none

package mcvm_pkg;

    localparam int CH_W        = 5;
    localparam int CTL_W       = 7;
    localparam int DATA_W      = 7;
    localparam int LEVEL_OUT_W = 24;
    localparam int MODE_W      = 3;

    localparam logic OP_MSG  = 1'b0;
    localparam logic OP_BIND = 1'b1;

    localparam logic [1:0] DEV_ABS    = 2'd0;
    localparam logic [1:0] DEV_REL    = 2'd1;
    localparam logic [1:0] DEV_MOM    = 2'd2;
    localparam logic [1:0] DEV_TOGGLE = 2'd3;

    localparam logic [2:0] FN_RANGE     = 3'd0;
    localparam logic [2:0] FN_UNBOUNDED = 3'd1;
    localparam logic [2:0] FN_CYCLIC    = 3'd2;
    localparam logic [2:0] FN_BUTTON    = 3'd3;
    localparam logic [2:0] FN_TOGGLE    = 3'd4;
    localparam logic [2:0] FN_LAST      = FN_TOGGLE;

    localparam logic [DATA_W-1:0] FULL_SCALE = 7'd127;

    typedef enum logic [MODE_W-1:0] {
        M_LINEAR    = 3'd0,
        M_CLAMPED   = 3'd1,
        M_CYCLIC    = 3'd2,
        M_UNBOUNDED = 3'd3,
        M_THRESHOLD = 3'd4,
        M_RELBUTTON = 3'd5,
        M_TOGGLE    = 3'd6
    } t_mode;

    typedef struct packed {
        logic              update;
        logic [DATA_W-1:0] position;
    } t_apply_ctl;

    function automatic t_mode mode_of(input logic [1:0] dev, input logic [2:0] fn);
        t_mode m;
        m = M_LINEAR;
        case (dev)
            DEV_ABS: begin
                if (fn == FN_BUTTON || fn == FN_TOGGLE) m = M_THRESHOLD;
            end
            DEV_REL: begin
                case (fn)
                    FN_RANGE:     m = M_CLAMPED;
                    FN_UNBOUNDED: m = M_UNBOUNDED;
                    FN_CYCLIC:    m = M_CYCLIC;
                    default:      m = M_RELBUTTON;
                endcase
            end
            DEV_MOM: begin
                if (fn == FN_TOGGLE) m = M_TOGGLE;
            end
            default: m = M_LINEAR;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/midi_controller_value_mapper.sv */
// top level of the midi controller value mapper: entry lookup sequencer and result register
// a message reads its own channel entry first and falls back to the channel 0 entry when that one is not bound
// the entry memory has a single read port: one lookup per cycle, write-back with result
// o_valid is registered with the write-back in S_LOOK; the wildcard fallback adds a read, i_stall delays it
// a bind with channel and function type in range writes its entry at the transfer
// after reset the entry memory is cleared, all (CHANNELS+1)*CONTROLLERS entries (2176 by default)
// o_stall stays high during the clearing pass; o_valid is low after reset
`timescale 1ns / 1ps
`default_nettype none
`include "midi_controller_value_mapper_defines.svh"

module midi_controller_value_mapper #(
    parameter int CHANNELS    = 16,
    parameter int CONTROLLERS = 128,
    parameter int LEVEL_BITS  = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic                                 i_operation,
    input  wire logic [mcvm_pkg::CH_W-1:0]            i_channel,
    input  wire logic [mcvm_pkg::CTL_W-1:0]           i_controller,
    input  wire logic [mcvm_pkg::DATA_W-1:0]          i_data_value,
    input  wire logic [1:0]                           i_device_type,
    input  wire logic [2:0]                           i_function_type,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [mcvm_pkg::CH_W-1:0]                 o_entry_channel,
    output logic [mcvm_pkg::CTL_W-1:0]                o_entry_controller,
    output logic signed [mcvm_pkg::LEVEL_OUT_W-1:0]   o_level
);

    localparam int SLOTS  = (CHANNELS + 1) * CONTROLLERS;
    localparam int AW     = $clog2(SLOTS);
    localparam int WORD_W = 1 + mcvm_pkg::MODE_W + mcvm_pkg::DATA_W + LEVEL_BITS;
    localparam int POS_LO = LEVEL_BITS;
    localparam int MODE_LO = POS_LO + mcvm_pkg::DATA_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0]                  r_clr, n_clr;
    logic [AW-1:0]                  r_addr, n_addr;
    logic [mcvm_pkg::CH_W-1:0]      r_ch, n_ch;
    logic [mcvm_pkg::CTL_W-1:0]     r_ctl, n_ctl;
    logic [mcvm_pkg::DATA_W-1:0]    r_data, n_data;
    logic                           r_out_valid, n_out_valid;
    logic [mcvm_pkg::CH_W-1:0]      r_out_ch, n_out_ch;
    logic [mcvm_pkg::CTL_W-1:0]     r_out_ctl, n_out_ctl;
    logic [mcvm_pkg::LEVEL_OUT_W-1:0] r_out_level, n_out_level;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [WORD_W-1:0]     mem_wdata, mem_rdata;

    logic                  in_xfer, ctl_ok, ch_ok, fn_ok, out_free;
    logic [AW-1:0]         own_addr;
    logic                  rd_valid;
    mcvm_pkg::t_mode       rd_mode;
    logic [mcvm_pkg::DATA_W-1:0] rd_pos;
    logic signed [LEVEL_BITS-1:0] rd_level;
    mcvm_pkg::t_apply_ctl  ap_ctl;
    logic signed [LEVEL_BITS-1:0] ap_level;
    logic signed [31:0]    level_wide;

    assign in_xfer  = i_valid && !o_stall;
    assign ctl_ok   = {1'b0, i_controller} < 8'(CONTROLLERS);
    assign ch_ok    = i_channel <= mcvm_pkg::CH_W'(CHANNELS);
    assign fn_ok    = i_function_type <= mcvm_pkg::FN_LAST;
    assign own_addr = AW'(i_channel) * AW'(CONTROLLERS) + AW'(i_controller);
    assign out_free = !r_out_valid || !i_stall;

    assign rd_valid = mem_rdata[WORD_W-1];
    assign rd_mode  = mcvm_pkg::t_mode'(mem_rdata[MODE_LO +: mcvm_pkg::MODE_W]);
    assign rd_pos   = mem_rdata[POS_LO +: mcvm_pkg::DATA_W];
    assign rd_level = signed'(mem_rdata[LEVEL_BITS-1:0]);

    assign level_wide = 32'($unsigned(ap_level));

    mcvm_entry_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mcvm_apply #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_apply (
        .i_mode     (rd_mode),
        .i_position (rd_pos),
        .i_level    (rd_level),
        .i_data     (r_data),
        .o_ctl      (ap_ctl),
        .o_level    (ap_level)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_ch        = r_ch;
        n_ctl       = r_ctl;
        n_data      = r_data;
        n_out_valid = r_out_valid && i_stall;
        n_out_ch    = r_out_ch;
        n_out_ctl   = r_out_ctl;
        n_out_level = r_out_level;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_xfer && ctl_ok) begin
                    if (i_operation == mcvm_pkg::OP_BIND) begin
                        if (ch_ok && fn_ok) begin
                            mem_we    = 1'b1;
                            mem_waddr = own_addr;
                            mem_wdata = {1'b1, mcvm_pkg::mode_of(i_device_type, i_function_type),
                                         {mcvm_pkg::DATA_W{1'b0}}, {LEVEL_BITS{1'b0}}};
                        end
                    end else begin
                        mem_re  = 1'b1;
                        n_ctl   = i_controller;
                        n_data  = i_data_value;
                        n_state = S_LOOK;
                        if (ch_ok) begin
                            mem_raddr = own_addr;
                            n_addr    = own_addr;
                            n_ch      = i_channel;
                        end else begin
                            mem_raddr = AW'(i_controller);
                            n_addr    = AW'(i_controller);
                            n_ch      = '0;
                        end
                    end
                end
            end
            S_LOOK: begin
                if (!rd_valid) begin
                    if (r_ch != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(r_ctl);
                        n_addr    = AW'(r_ctl);
                        n_ch      = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!ap_ctl.update) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_addr;
                    mem_wdata   = {1'b1, rd_mode, ap_ctl.position, ap_level};
                    n_out_valid = 1'b1;
                    n_out_ch    = r_ch;
                    n_out_ctl   = r_ctl;
                    n_out_level = level_wide[mcvm_pkg::LEVEL_OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_ch        <= n_ch;
        r_ctl       <= n_ctl;
        r_data      <= n_data;
        r_out_ch    <= n_out_ch;
        r_out_ctl   <= n_out_ctl;
        r_out_level <= n_out_level;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_entry_channel    = r_out_ch;
    assign o_entry_controller = r_out_ctl;
    assign o_level            = signed'(r_out_level);

    `MCVM_ASSERT_NEXT(a_writeback_gives_result, (r_state == S_LOOK) && mem_we, o_valid, "write-back without a result")
    `MCVM_ASSERT_NOW(a_no_result_while_clearing, r_state == S_CLEAR, !o_valid, "result during clearing pass")
    `MCVM_ASSERT_NEXT(a_retry_goes_wildcard, (r_state == S_LOOK) && mem_re, (r_state == S_LOOK) && (r_ch == '0), "second lookup not on channel 0")

endmodule

`default_nettype wire

/* hw/rtl/mcvm_entry_ram.sv */
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mcvm_entry_ram #(
    parameter int DEPTH = 2176,
    parameter int WIDTH = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mcvm_apply.sv */
// mode update: new position and level of one entry from a data byte
`timescale 1ns / 1ps
`default_nettype none

module mcvm_apply #(
    parameter int LEVEL_BITS = 24
) (
    input  wire mcvm_pkg::t_mode                  i_mode,
    input  wire logic [mcvm_pkg::DATA_W-1:0]      i_position,
    input  wire logic signed [LEVEL_BITS-1:0]     i_level,
    input  wire logic [mcvm_pkg::DATA_W-1:0]      i_data,
    output mcvm_pkg::t_apply_ctl                  o_ctl,
    output logic signed [LEVEL_BITS-1:0]          o_level
);

    localparam int LW = LEVEL_BITS + 1;
    localparam logic signed [LW-1:0] LMAX = LW'((64'd1 << (LEVEL_BITS - 1)) - 64'd1);
    localparam logic signed [LW-1:0] LMIN = -LMAX;

    logic signed [7:0]    delta;
    logic signed [8:0]    p_sum;
    logic signed [LW-1:0] acc;
    logic [6:0]           p_next;

    assign delta = signed'({i_data[6], i_data});
    assign p_sum = signed'({2'b00, i_position}) + 9'(delta);
    assign acc   = LW'(i_level) + LW'(delta);

    always_comb begin
        o_ctl.update   = 1'b1;
        o_ctl.position = i_position;
        o_level        = LEVEL_BITS'(i_data);
        p_next         = 7'd0;
        case (i_mode)
            mcvm_pkg::M_CLAMPED: begin
                if (p_sum < 9'sd0) begin
                    p_next = 7'd0;
                end else if (p_sum > 9'sd127) begin
                    p_next = mcvm_pkg::FULL_SCALE;
                end else begin
                    p_next = p_sum[6:0];
                end
                o_ctl.position = p_next;
                o_level        = LEVEL_BITS'(p_next);
            end
            mcvm_pkg::M_CYCLIC: begin
                p_next         = i_position + i_data;
                o_ctl.position = p_next;
                o_level        = LEVEL_BITS'(p_next);
            end
            mcvm_pkg::M_UNBOUNDED: begin
                if (acc > LMAX) begin
                    o_level = LMAX[LEVEL_BITS-1:0];
                end else if (acc < LMIN) begin
                    o_level = LMIN[LEVEL_BITS-1:0];
                end else begin
                    o_level = acc[LEVEL_BITS-1:0];
                end
            end
            mcvm_pkg::M_THRESHOLD: begin
                o_level = i_data[6] ? LEVEL_BITS'(mcvm_pkg::FULL_SCALE) : '0;
            end
            mcvm_pkg::M_RELBUTTON: begin
                o_ctl.update = (i_data != '0);
                o_level      = i_data[6] ? '0 : LEVEL_BITS'(mcvm_pkg::FULL_SCALE);
            end
            mcvm_pkg::M_TOGGLE: begin
                o_ctl.update   = (i_data != '0);
                p_next         = (i_position != '0) ? 7'd0 : 7'd1;
                o_ctl.position = p_next;
                o_level        = (p_next != '0) ? LEVEL_BITS'(mcvm_pkg::FULL_SCALE) : '0;
            end
            default: begin
                o_level = LEVEL_BITS'(i_data);
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the midi controller value mapper
`timescale 1ns / 1ps

module testbench;
    import mcvm_pkg::*;

    localparam int N_CH        = 16;
    localparam int N_CTL       = 128;
    localparam int SLOT_COUNT  = (N_CH + 1) * N_CTL;
    localparam int LEVEL_LIMIT = (1 << (LEVEL_OUT_W - 1)) - 1;
    localparam int FULL        = int'(FULL_SCALE);
    localparam int RANDOM_ITEMS = 620;

    localparam logic [2:0] FN_BAD_LO = FN_LAST + 3'd1;
    localparam logic [2:0] FN_BAD_HI = 3'h7;

    localparam t_mode MODE_GRID [4][5] = '{
        '{M_LINEAR,  M_LINEAR,    M_LINEAR, M_THRESHOLD, M_THRESHOLD},
        '{M_CLAMPED, M_UNBOUNDED, M_CYCLIC, M_RELBUTTON, M_RELBUTTON},
        '{M_LINEAR,  M_LINEAR,    M_LINEAR, M_LINEAR,    M_TOGGLE},
        '{M_LINEAR,  M_LINEAR,    M_LINEAR, M_LINEAR,    M_LINEAR}
    };

    localparam logic [CTL_W-1:0]  CTL_POOL [8]  = '{7'd0, 7'd127, 7'd1, 7'd64,
                                                   7'd63, 7'd5, 7'd85, 7'd42};
    localparam logic [DATA_W-1:0] DATA_EDGE [4] = '{7'd0, 7'd63, 7'd64, 7'd127};

    typedef struct packed {
        logic              op;
        logic [CH_W-1:0]   ch;
        logic [CTL_W-1:0]  ctl;
        logic [DATA_W-1:0] data;
        logic [1:0]        dev;
        logic [2:0]        fn;
    } t_item;

    typedef struct packed {
        logic [CH_W-1:0]               ch;
        logic [CTL_W-1:0]              ctl;
        logic signed [LEVEL_OUT_W-1:0] level;
    } t_level_out;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_TYPED
    } t_check;

    typedef struct packed {
        t_item      it;
        t_check     chk;
        t_level_out want;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic                          i_operation;
    logic [CH_W-1:0]               i_channel;
    logic [CTL_W-1:0]              i_controller;
    logic [DATA_W-1:0]             i_data_value;
    logic [1:0]                    i_device_type;
    logic [2:0]                    i_function_type;
    logic                          o_valid;
    logic                          i_stall;
    logic [CH_W-1:0]               o_entry_channel;
    logic [CTL_W-1:0]              o_entry_controller;
    logic signed [LEVEL_OUT_W-1:0] o_level;

    bit         slot_bound [SLOT_COUNT];
    t_mode      slot_mode  [SLOT_COUNT];
    logic [6:0] slot_pos   [SLOT_COUNT];
    int         slot_level [SLOT_COUNT];

    t_level_out pending_levels [$];
    int         levels_seen;
    int         error_count;
    int         cycle_count;

    midi_controller_value_mapper dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_channel          (i_channel),
        .i_controller       (i_controller),
        .i_data_value       (i_data_value),
        .i_device_type      (i_device_type),
        .i_function_type    (i_function_type),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_entry_channel    (o_entry_channel),
        .o_entry_controller (o_entry_controller),
        .o_level            (o_level)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // returns 1 when the transfer updates a target
    function automatic bit map_transfer(input t_item it, output t_level_out res);
        int slot;
        int d;
        int p;
        int lvl;
        logic [CH_W-1:0] src;
        res  = '0;
        lvl  = 0;
        if (it.op == OP_BIND) begin
            if (int'(it.ch) > N_CH || it.fn > FN_LAST) return 1'b0;
            slot = int'(it.ch) * N_CTL + int'(it.ctl);
            slot_bound[slot] = 1'b1;
            slot_mode[slot]  = MODE_GRID[it.dev][it.fn];
            slot_pos[slot]   = '0;
            slot_level[slot] = 0;
            return 1'b0;
        end
        src = it.ch;
        if (int'(it.ch) > N_CH || !slot_bound[int'(it.ch) * N_CTL + int'(it.ctl)]) src = '0;
        slot = int'(src) * N_CTL + int'(it.ctl);
        if (!slot_bound[slot]) return 1'b0;
        d = (it.data < 7'd64) ? int'(it.data) : int'(it.data) - 128;
        p = int'(slot_pos[slot]);
        case (slot_mode[slot])
            M_CLAMPED: begin
                p = p + d;
                if (p > 127) p = 127;
                if (p < 0) p = 0;
                slot_pos[slot] = 7'(p);
                lvl = p;
            end
            M_CYCLIC: begin
                p = (p + d + 128) % 128;
                slot_pos[slot] = 7'(p);
                lvl = p;
            end
            M_UNBOUNDED: begin
                lvl = slot_level[slot] + d;
                if (lvl > LEVEL_LIMIT) lvl = LEVEL_LIMIT;
                if (lvl < -LEVEL_LIMIT) lvl = -LEVEL_LIMIT;
            end
            M_THRESHOLD: begin
                lvl = (it.data > 7'd63) ? FULL : 0;
            end
            M_RELBUTTON: begin
                if (it.data == '0) return 1'b0;
                lvl = it.data[6] ? 0 : FULL;
            end
            M_TOGGLE: begin
                if (it.data == '0) return 1'b0;
                slot_pos[slot] = (slot_pos[slot] != '0) ? 7'd0 : 7'd1;
                lvl = (slot_pos[slot] != '0) ? FULL : 0;
            end
            default: begin
                lvl = int'(it.data);
            end
        endcase
        slot_level[slot] = lvl;
        res.ch    = src;
        res.ctl   = it.ctl;
        res.level = LEVEL_OUT_W'(lvl);
        return 1'b1;
    endfunction

    function automatic t_row bind_row(input logic [CH_W-1:0] ch, input logic [CTL_W-1:0] ctl,
                                      input logic [1:0] dev, input logic [2:0] fn);
        t_row r;
        r      = '0;
        r.it   = '{op: OP_BIND, ch: ch, ctl: ctl, data: '0, dev: dev, fn: fn};
        r.chk  = CHK_NONE;
        return r;
    endfunction

    function automatic t_row msg_row(input logic [CH_W-1:0] ch, input logic [CTL_W-1:0] ctl,
                                     input logic [DATA_W-1:0] data, input t_check chk,
                                     input logic [CH_W-1:0] src, input int lvl);
        t_row r;
        r            = '0;
        r.it         = '{op: OP_MSG, ch: ch, ctl: ctl, data: data, dev: '0, fn: '0};
        r.chk        = chk;
        r.want.ch    = src;
        r.want.ctl   = ctl;
        r.want.level = LEVEL_OUT_W'(lvl);
        return r;
    endfunction

    function automatic int sender_gap(input int n);
        int r;
        r = $urandom_range(0, 99);
        if ((n / 60) % 3 == 0) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int receiver_hold();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count / 400) % 4 == 0) return 0;
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic offer(input t_item it, input t_check chk, input t_level_out typed);
        t_level_out want;
        bit         has;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_operation     <= it.op;
        i_channel       <= it.ch;
        i_controller    <= it.ctl;
        i_data_value    <= it.data;
        i_device_type   <= it.dev;
        i_function_type <= it.fn;
        do @(posedge i_clk); while (o_stall);
        has = map_transfer(it, want);
        case (chk)
            CHK_PREDICT: if (has) pending_levels.push_back(want);
            CHK_TYPED:   pending_levels.push_back(typed);
            default:     ;
        endcase
    endtask

    task automatic hold_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // result side: random stall, one long hold-off, and the field compare
    initial begin : result_side
        int         hold;
        bit         pressed;
        t_level_out want;
        hold    = 0;
        pressed = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) hold = receiver_hold();
            if (!pressed && levels_seen >= 150) begin
                hold    = 90;
                pressed = 1'b1;
            end
            i_stall <= (hold > 0);
            if (hold > 0) hold = hold - 1;
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                levels_seen = levels_seen + 1;
                if (pending_levels.size() == 0) begin
                    $error("unexpected transfer: channel %0d controller %0d level %0d",
                           o_entry_channel, o_entry_controller, o_level);
                    error_count = error_count + 1;
                end else begin
                    want = pending_levels.pop_front();
                    if (o_entry_channel !== want.ch) begin
                        $error("entry_channel: expected %0d, got %0d", want.ch, o_entry_channel);
                        error_count = error_count + 1;
                    end
                    if (o_entry_controller !== want.ctl) begin
                        $error("entry_controller: expected %0d, got %0d",
                               want.ctl, o_entry_controller);
                        error_count = error_count + 1;
                    end
                    if (o_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, o_level);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    initial begin : timeout
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_row       script [$];
        t_item      it;
        t_level_out none;
        int         n;
        none            = '0;
        levels_seen     = 0;
        error_count     = 0;
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = OP_MSG;
        i_channel       = '0;
        i_controller    = '0;
        i_data_value    = '0;
        i_device_type   = DEV_ABS;
        i_function_type = FN_RANGE;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_bound[s] = 1'b0;
            slot_mode[s]  = M_LINEAR;
            slot_pos[s]   = '0;
            slot_level[s] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // nothing bound yet, then wildcard fallback and out-of-range channels
        script.push_back(msg_row(5'd1, 7'd5, 7'd10, CHK_NONE, 5'd0, 0));
        script.push_back(bind_row(5'd0, 7'd5, DEV_ABS, FN_RANGE));
        script.push_back(msg_row(5'd3, 7'd5, 7'd127, CHK_TYPED, 5'd0, 127));
        script.push_back(msg_row(5'd31, 7'd5, 7'd0, CHK_TYPED, 5'd0, 0));
        script.push_back(bind_row(5'd17, 7'd5, DEV_MOM, FN_RANGE));
        script.push_back(msg_row(5'd17, 7'd5, 7'd64, CHK_TYPED, 5'd0, 64));
        script.push_back(bind_row(5'd16, 7'd127, DEV_REL, FN_BAD_LO));
        script.push_back(bind_row(5'd16, 7'd127, DEV_REL, FN_BAD_HI));
        // clamped position at both ends
        script.push_back(bind_row(5'd16, 7'd127, DEV_REL, FN_RANGE));
        script.push_back(msg_row(5'd16, 7'd127, 7'd127, CHK_TYPED, 5'd16, 0));
        script.push_back(msg_row(5'd16, 7'd127, 7'd63, CHK_TYPED, 5'd16, 63));
        script.push_back(msg_row(5'd16, 7'd127, 7'd63, CHK_PREDICT, 5'd16, 0));
        script.push_back(msg_row(5'd16, 7'd127, 7'd2, CHK_TYPED, 5'd16, 127));
        // cyclic wrap and unbounded negative
        script.push_back(bind_row(5'd1, 7'd0, DEV_REL, FN_CYCLIC));
        script.push_back(msg_row(5'd1, 7'd0, 7'd64, CHK_TYPED, 5'd1, 64));
        script.push_back(bind_row(5'd2, 7'd1, DEV_REL, FN_UNBOUNDED));
        script.push_back(msg_row(5'd2, 7'd1, 7'd64, CHK_TYPED, 5'd2, -64));
        // threshold, relative button and toggle
        script.push_back(bind_row(5'd3, 7'd2, DEV_ABS, FN_BUTTON));
        script.push_back(msg_row(5'd3, 7'd2, 7'd63, CHK_TYPED, 5'd3, 0));
        script.push_back(msg_row(5'd3, 7'd2, 7'd64, CHK_TYPED, 5'd3, 127));
        script.push_back(bind_row(5'd4, 7'd3, DEV_REL, FN_BUTTON));
        script.push_back(msg_row(5'd4, 7'd3, 7'd0, CHK_NONE, 5'd4, 0));
        script.push_back(msg_row(5'd4, 7'd3, 7'd64, CHK_TYPED, 5'd4, 0));
        script.push_back(msg_row(5'd4, 7'd3, 7'd1, CHK_TYPED, 5'd4, 127));
        script.push_back(bind_row(5'd5, 7'd4, DEV_MOM, FN_TOGGLE));
        script.push_back(msg_row(5'd5, 7'd4, 7'd0, CHK_NONE, 5'd5, 0));
        script.push_back(msg_row(5'd5, 7'd4, 7'd5, CHK_TYPED, 5'd5, 127));
        script.push_back(msg_row(5'd5, 7'd4, 7'd5, CHK_TYPED, 5'd5, 0));

        foreach (script[k]) begin
            offer(script[k].it, script[k].chk, script[k].want);
            hold_sender(sender_gap(k + 60));
        end

        // random part: mostly binds and messages on a small set of controllers
        n = 0;
        while (n < RANDOM_ITEMS) begin
            it.op = ($urandom_range(0, 99) < 15) ? OP_BIND : OP_MSG;
            if ($urandom_range(0, 9) == 0) it.ch = CH_W'($urandom_range(17, 31));
            else if (it.op == OP_BIND && $urandom_range(0, 3) == 0) it.ch = '0;
            else it.ch = CH_W'($urandom_range(0, N_CH));
            if ($urandom_range(0, 3) == 0) it.ctl = CTL_W'($urandom);
            else it.ctl = CTL_POOL[$urandom_range(0, 7)];
            case ($urandom_range(0, 3))
                0:       it.data = DATA_W'($urandom_range(0, 3));
                1:       it.data = DATA_W'(128 - $urandom_range(1, 3));
                2:       it.data = DATA_EDGE[$urandom_range(0, 3)];
                default: it.data = DATA_W'($urandom);
            endcase
            it.dev = 2'($urandom);
            if ($urandom_range(0, 9) == 0) it.fn = 3'($urandom_range(5, 7));
            else it.fn = 3'($urandom_range(0, 4));
            offer(it, CHK_PREDICT, none);
            hold_sender(sender_gap(n));
            n = n + 1;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_levels.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_levels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
